### hw/rtl/sorted_matrix_binary_search_defines.svh
// ----------------------------------------------------------------------------
// Sorted matrix binary search: assertion macros
// Concurrent assertion helpers sampled on clk_i and disabled while rst_ni is
// low. They expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_MATRIX_BINARY_SEARCH_DEFINES_SVH
`define SORTED_MATRIX_BINARY_SEARCH_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define SMS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted matrix search: same-cycle check failed");
// Next-cycle implication.
`define SMS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted matrix search: next-cycle check failed");
`else
`define SMS_ASSERT_IMPL(name, ante, cons)
`define SMS_ASSERT_NEXT(name, ante, cons)
`endif

`endif

### hw/rtl/sms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted matrix binary search package
// Shared widths, codes and the command and status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int unsigned CNT_W        = 5;
  localparam int unsigned IDX_W        = 2 * CNT_W;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned MAX_ROWS_DEF = 16;
  localparam int unsigned MAX_COLS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef struct packed {
    logic load_entry;
    logic latch;
    logic rd_first;
    logic rd_last;
    logic div_start;
    logic rd_probe;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic below;
    logic above;
    logic hit;
    logic div_done;
    logic range_empty;
  } sts_t;

endpackage

### hw/rtl/sms_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Probe index divider
// Restoring divider, one quotient bit per cycle, that splits a flattened
// probe index into row (quotient) and column (remainder).
// ----------------------------------------------------------------------------
module sms_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sms_pkg::IDX_W-1:0] dividend_i,
  input  logic [sms_pkg::CNT_W-1:0] divisor_i,
  output logic [sms_pkg::IDX_W-1:0] quot_o,
  output logic [sms_pkg::CNT_W-1:0] rem_o,
  output logic                      done_o
);

  localparam int unsigned STEP_W = $clog2(sms_pkg::IDX_W);

  logic [sms_pkg::IDX_W-1:0] dq_q, dq_d;
  logic [sms_pkg::CNT_W-1:0] rem_q, rem_d;
  logic [STEP_W-1:0]         cnt_q, cnt_d;
  logic                      run_q, run_d;
  logic                      done_q, done_d;
  logic [sms_pkg::CNT_W:0]   trial;
  logic [sms_pkg::CNT_W:0]   diff;
  logic                      fits;

  // The dividend shifts out at the top while quotient bits shift in below.
  assign trial = {rem_q, dq_q[sms_pkg::IDX_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = done_q;
    if (start_i) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      run_d  = 1'b1;
      done_d = 1'b0;
    end else if (run_q) begin
      dq_d  = {dq_q[sms_pkg::IDX_W-2:0], fits};
      rem_d = fits ? diff[sms_pkg::CNT_W-1:0] : trial[sms_pkg::CNT_W-1:0];
      cnt_d = cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(sms_pkg::IDX_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
  end

  assign quot_o = dq_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

### hw/rtl/sms_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted matrix search datapath
// Configuration registers, the entry store, the search bounds and the
// probe divider. Acts on commands from the controller and returns status.
// ----------------------------------------------------------------------------
module sms_datapath #(
  parameter int unsigned MAX_ROWS = sms_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = sms_pkg::MAX_COLS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sms_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sms_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  logic [sms_pkg::POS_W-1:0]         entry_row_i,
  input  logic [sms_pkg::POS_W-1:0]         entry_col_i,
  input  logic signed [sms_pkg::DATA_W-1:0] entry_value_i,
  input  logic signed [sms_pkg::DATA_W-1:0] target_i,
  input  sms_pkg::cmd_t                     cmd_i,
  output sms_pkg::sts_t                     sts_o
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LIN_W = sms_pkg::IDX_W + $clog2(MAX_COLS + 1) + 1;

  logic [sms_pkg::CNT_W-1:0]         row_cnt_q, col_cnt_q;
  logic [sms_pkg::CNT_W-1:0]         rows_q, cols_q;
  logic [sms_pkg::CNT_W-1:0]         rows_eff, cols_eff;
  logic signed [sms_pkg::DATA_W-1:0] tgt_q;
  logic signed [sms_pkg::DATA_W-1:0] rdata_q;
  logic [sms_pkg::IDX_W-1:0]         lo_q, hix_q, mid_q;
  logic [sms_pkg::IDX_W:0]           mid_sum;
  logic [sms_pkg::IDX_W-1:0]         mid_w;
  logic [sms_pkg::IDX_W-1:0]         quot;
  logic [sms_pkg::CNT_W-1:0]         rem;
  logic                              div_done;
  logic [LIN_W-1:0]                  wr_lin, last_lin, probe_lin, rd_lin;
  logic                              wr_ok, rd_en;
  logic [sms_pkg::DATA_W-1:0]        store_q [DEPTH];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      col_cnt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sms_pkg::CFG_ROW_COUNT: row_cnt_q <= cfg_wdata_i;
        sms_pkg::CFG_COL_COUNT: col_cnt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Counts beyond the store size saturate to the store size.
  assign rows_eff = (32'(row_cnt_q) > MAX_ROWS) ? sms_pkg::CNT_W'(MAX_ROWS) : row_cnt_q;
  assign cols_eff = (32'(col_cnt_q) > MAX_COLS) ? sms_pkg::CNT_W'(MAX_COLS) : col_cnt_q;

  // Midpoint of the half-open range [lo, hix).
  assign mid_sum = (sms_pkg::IDX_W+1)'(lo_q) + (sms_pkg::IDX_W+1)'(hix_q)
                 - (sms_pkg::IDX_W+1)'(1);
  assign mid_w   = mid_sum[sms_pkg::IDX_W:1];

  sms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mid_w),
    .divisor_i  (cols_q),
    .quot_o     (quot),
    .rem_o      (rem),
    .done_o     (div_done)
  );

  assign wr_ok  = (32'(entry_row_i) < MAX_ROWS) && (32'(entry_col_i) < MAX_COLS);
  assign wr_lin = LIN_W'(entry_row_i) * LIN_W'(MAX_COLS) + LIN_W'(entry_col_i);
  assign last_lin = LIN_W'(rows_q - sms_pkg::CNT_W'(1)) * LIN_W'(MAX_COLS)
                  + LIN_W'(cols_q - sms_pkg::CNT_W'(1));
  assign probe_lin = LIN_W'(quot) * LIN_W'(MAX_COLS) + LIN_W'(rem);

  always_comb begin
    rd_en  = cmd_i.rd_first | cmd_i.rd_last | cmd_i.rd_probe;
    rd_lin = '0;
    if (cmd_i.rd_last) begin
      rd_lin = last_lin;
    end else if (cmd_i.rd_probe) begin
      rd_lin = probe_lin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_entry && wr_ok) begin
      store_q[wr_lin[AW-1:0]] <= entry_value_i;
    end
    if (rd_en) begin
      rdata_q <= store_q[rd_lin[AW-1:0]];
    end
  end

  // Search operands and bounds.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      rows_q <= rows_eff;
      cols_q <= cols_eff;
      tgt_q  <= target_i;
      lo_q   <= '0;
      hix_q  <= sms_pkg::IDX_W'(rows_eff) * sms_pkg::IDX_W'(cols_eff);
    end else if (cmd_i.update) begin
      if (tgt_q < rdata_q) begin
        hix_q <= mid_q;
      end else begin
        lo_q <= mid_q + sms_pkg::IDX_W'(1);
      end
    end
    if (cmd_i.div_start) begin
      mid_q <= mid_w;
    end
  end

  always_comb begin
    sts_o             = '0;
    sts_o.empty       = (rows_q == '0) || (cols_q == '0);
    sts_o.below       = (tgt_q < rdata_q);
    sts_o.above       = (tgt_q > rdata_q);
    sts_o.hit         = (tgt_q == rdata_q);
    sts_o.div_done    = div_done;
    sts_o.range_empty = (lo_q >= hix_q);
  end

endmodule

### hw/rtl/sms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted matrix search controller
// Issues entry loads, sequences the end checks and the probe loop, and drives the result strobe.
// ----------------------------------------------------------------------------
module sms_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          action_i,
  input  sms_pkg::sts_t sts_i,
  output sms_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o,
  output logic          found_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INIT  = 7'b0000010,
    S_FIRST = 7'b0000100,
    S_LAST  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_CMP   = 7'b0100000,
    S_NEXT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  logic   found_q, found_d;
  logic   accept;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    done_d  = 1'b0;
    found_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_i == sms_pkg::ACT_LOAD) begin
            cmd_o.load_entry = 1'b1;
          end else begin
            cmd_o.latch = 1'b1;
            state_d     = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (sts_i.empty) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_first = 1'b1;
          state_d        = S_FIRST;
        end
      end
      S_FIRST: begin
        if (sts_i.below) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_last = 1'b1;
          state_d       = S_LAST;
        end
      end
      S_LAST: begin
        if (sts_i.above) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        // The probe read is issued in the cycle the split index is ready.
        if (sts_i.div_done) begin
          cmd_o.rd_probe = 1'b1;
          state_d        = S_CMP;
        end
      end
      S_CMP: begin
        if (sts_i.hit) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.update = 1'b1;
          state_d      = S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts_i.range_empty) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      found_q <= found_d;
    end
  end

  assign done_o  = done_q;
  assign found_o = found_q;

endmodule

### hw/rtl/sorted_matrix_binary_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted matrix binary search
// Membership search over a row-major sorted matrix of signed 32-bit entries.
// ----------------------------------------------------------------------------
// A word is taken at a clock edge where start is high and busy is low. A load
// word (action 0) writes one entry in that same cycle and leaves busy low, so
// loads can arrive every cycle; loads outside the store are dropped. A search
// word (action 1) raises busy and ends with one cycle of done_o carrying
// found_o, after which busy is already low; the receiver must take that word
// in that cycle. A search ends after the empty check for an empty matrix,
// after the first or last entry read when the target lies outside the end
// entries, and otherwise after a probe that hits or once the range is empty,
// with at most ceil(log2(rows * cols + 1)) probes, so 9 for a full 16 x 16
// matrix. Each probe runs the bit-serial divider that splits the probe index
// into row and column, then the registered store read, then the narrowing of
// the bounds. Configuration writes land at once and must only be made while
// busy is low.
// ----------------------------------------------------------------------------
`include "sorted_matrix_binary_search_defines.svh"

module sorted_matrix_binary_search #(
  parameter int unsigned MAX_ROWS = sms_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = sms_pkg::MAX_COLS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sms_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sms_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  logic                              start,
  output logic                              busy,
  input  logic                              action_i,
  input  logic [sms_pkg::POS_W-1:0]         entry_row_i,
  input  logic [sms_pkg::POS_W-1:0]         entry_col_i,
  input  logic signed [sms_pkg::DATA_W-1:0] entry_value_i,
  input  logic signed [sms_pkg::DATA_W-1:0] target_i,
  output logic                              done_o,
  output logic                              found_o
);

  sms_pkg::cmd_t cmd;
  sms_pkg::sts_t sts;

  sms_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (action_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o),
    .found_o  (found_o)
  );

  sms_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .entry_row_i   (entry_row_i),
    .entry_col_i   (entry_col_i),
    .entry_value_i (entry_value_i),
    .target_i      (target_i),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

  // A result only appears once the search has released the block.
  `SMS_ASSERT_IMPL(a_done_when_idle, done_o, !busy)
  `SMS_ASSERT_IMPL(a_found_with_done, found_o, done_o)
  `SMS_ASSERT_NEXT(a_search_holds_busy, start && !busy && (action_i == sms_pkg::ACT_SEARCH), busy)
  `SMS_ASSERT_NEXT(a_load_is_silent, start && !busy && (action_i == sms_pkg::ACT_LOAD), !busy && !done_o)

endmodule
